@@ rtl/dpcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dpcp_pkg
// Shared constants and types of the dual pattern common position unit.
// ----------------------------------------------------------------------------
package dpcp_pkg;

    localparam int MAX_PATTERN_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int PAT_W     = 64;
    localparam int PAT_IDX_W = 3;
    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [PAT_W-1:0]  pattern_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_A     = 2'd0,
        CFG_PATTERN_A_LEN = 2'd1,
        CFG_PATTERN_B     = 2'd2,
        CFG_PATTERN_B_LEN = 2'd3
    } cfg_idx_t;

    // one window slot of both strings
    typedef struct packed {
        byte_t byte_a;
        logic  pres_a;
        byte_t byte_b;
        logic  pres_b;
    } win_t;

    // per-request step information handed to the control block
    typedef struct packed {
        logic accept;
        logic last;
        logic hit;
        len_t longer;
        logic empty;
    } step_t;

    typedef struct packed {
        logic slot_free;
        logic searching;
    } ctrl_status_t;

endpackage

@@ rtl/dpcp_ifs.sv @@
// ----------------------------------------------------------------------------
// dpcp channel interfaces
// Valid/ready channels for input requests and results.
// ----------------------------------------------------------------------------
interface dpcp_item_if;
    logic            valid;
    logic            ready;
    dpcp_pkg::byte_t byte_a;
    logic            has_a;
    dpcp_pkg::byte_t byte_b;
    logic            has_b;
    logic            last;

    modport source (output valid, output byte_a, output has_a, output byte_b,
                    output has_b, output last, input ready);
    modport sink   (input valid, input byte_a, input has_a, input byte_b,
                    input has_b, input last, output ready);
endinterface

interface dpcp_result_if;
    logic                          valid;
    logic                          ready;
    logic [dpcp_pkg::POS_W-1:0]    position;
    logic                          overflow;

    modport source (output valid, output position, output overflow, input ready);
    modport sink   (input valid, input position, input overflow, output ready);
endinterface

@@ rtl/dpcp_cell.sv @@
// ----------------------------------------------------------------------------
// dpcp_cell
// One window slot: holds a byte of each string, presence flags and the
// match history bits, and compares its slot against the pattern byte.
// ----------------------------------------------------------------------------
module dpcp_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               clear,
    input  dpcp_pkg::win_t     win_in,
    input  logic               hit_a_in,
    input  logic               hit_b_in,
    input  dpcp_pkg::len_t     len_a,
    input  dpcp_pkg::len_t     len_b,
    input  dpcp_pkg::pattern_t pattern_a,
    input  dpcp_pkg::pattern_t pattern_b,
    output dpcp_pkg::win_t     win_q,
    output logic               hit_a_q,
    output logic               hit_b_q,
    output logic               ok_a,
    output logic               ok_b
);

    localparam dpcp_pkg::len_t K   = dpcp_pkg::len_t'(INDEX);
    localparam dpcp_pkg::len_t ONE = dpcp_pkg::len_t'(1);

    dpcp_pkg::win_t  win_reg, win_next;
    logic            hit_a_reg, hit_a_next;
    logic            hit_b_reg, hit_b_next;
    dpcp_pkg::len_t  sel_a, sel_b;
    dpcp_pkg::byte_t pat_byte_a, pat_byte_b;

    // slot k of the window lines up with pattern byte len-1-k
    assign sel_a      = len_a - K - ONE;
    assign sel_b      = len_b - K - ONE;
    assign pat_byte_a = pattern_a[{sel_a[dpcp_pkg::PAT_IDX_W-1:0], 3'b000} +: dpcp_pkg::BYTE_W];
    assign pat_byte_b = pattern_b[{sel_b[dpcp_pkg::PAT_IDX_W-1:0], 3'b000} +: dpcp_pkg::BYTE_W];

    // compare against the value the slot takes this cycle
    assign ok_a = (K >= len_a) || (win_in.pres_a && (win_in.byte_a == pat_byte_a));
    assign ok_b = (K >= len_b) || (win_in.pres_b && (win_in.byte_b == pat_byte_b));

    always_comb
    begin
        win_next   = win_reg;
        hit_a_next = hit_a_reg;
        hit_b_next = hit_b_reg;
        if (clear)
        begin
            win_next   = '0;
            hit_a_next = 1'b0;
            hit_b_next = 1'b0;
        end
        else if (advance)
        begin
            win_next   = win_in;
            hit_a_next = hit_a_in;
            hit_b_next = hit_b_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            hit_a_reg <= hit_a_next;
            hit_b_reg <= hit_b_next;
        end
    end

    assign win_q   = win_reg;
    assign hit_a_q = hit_a_reg;
    assign hit_b_q = hit_b_reg;

endmodule

@@ rtl/dpcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpcp_ctrl
// Position counter, first-hit capture, overflow flag and result register.
// ----------------------------------------------------------------------------
module dpcp_ctrl #(
    parameter int POSITION_BITS = dpcp_pkg::POSITION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpcp_pkg::step_t        step,
    output dpcp_pkg::ctrl_status_t status,
    dpcp_result_if.source          result
);

    localparam int PW = dpcp_pkg::POS_W;
    localparam logic [POSITION_BITS-1:0] LIMIT = '1;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [POSITION_BITS-1:0] found_reg, found_next, found_step;
    logic                     ovf_reg, ovf_next, ovf_step;
    logic                     valid_reg, valid_next;
    logic [PW-1:0]            position_reg, position_next;
    logic                     overflow_reg, overflow_next;
    logic                     searching;

    assign searching = (count_reg != LIMIT);

    always_comb
    begin
        count_next    = count_reg;
        found_step    = found_reg;
        ovf_step      = ovf_reg;
        valid_next    = valid_reg;
        position_next = position_reg;
        overflow_next = overflow_reg;

        if (valid_reg && result.ready)
            valid_next = 1'b0;

        if (step.accept)
        begin
            if (searching)
            begin
                count_next = count_reg + POSITION_BITS'(1);
                // start of the match that completes on this request, 1-based
                if (step.hit && (found_reg == '0))
                    found_step = count_reg + POSITION_BITS'(2)
                               - POSITION_BITS'(step.longer);
            end
            else
            begin
                ovf_step = 1'b1;
            end
        end

        found_next = found_step;
        ovf_next   = ovf_step;

        if (step.accept && step.last)
        begin
            valid_next    = 1'b1;
            position_next = step.empty ? '0 : PW'(found_step);
            overflow_next = ovf_step;
            count_next    = '0;
            found_next    = '0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg <= position_next;
        overflow_reg <= overflow_next;
    end

    assign result.valid    = valid_reg;
    assign result.position = position_reg;
    assign result.overflow = overflow_reg;

    assign status.slot_free = !valid_reg || result.ready;
    assign status.searching = searching;

endmodule

@@ rtl/dual_pattern_common_position_unit.sv @@
// ----------------------------------------------------------------------------
// dual_pattern_common_position_unit
// Finds the first position where pattern A starts in string A and pattern B
// starts in string B, with both strings streamed in side by side.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one request per cycle, while item.ready is high, carries a byte of each string with
//   presence flags; last marks the final request of a string pair.
//   result channel: one result per pair, the 1-based common start position
//   (0 when none or when either pattern is empty) and an overflow flag.
//   cfg port: cfg_we writes cfg_data into the register at cfg_index
//   (pattern_a, pattern_a_len, pattern_b, pattern_b_len); write only while idle.
// Throughput: one request per cycle while item.ready is high; the window is a row of
//   MAX_PATTERN cells that shift on each request taken while searching and compare in
//   parallel, so the compare and hit selection are combinational for every request.
// Latency: the result is valid the cycle after the last request is accepted.
// Stall: the result is held in an output register; item.ready drops only while
//   a result is waiting and result.ready is low.
// Reset: clears patterns, lengths, window, counters and the result valid.
// ----------------------------------------------------------------------------
module dual_pattern_common_position_unit #(
    parameter int MAX_PATTERN   = dpcp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = dpcp_pkg::POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dpcp_item_if.sink             item,
    dpcp_result_if.source         result,
    input  logic                  cfg_we,
    input  dpcp_pkg::cfg_idx_t    cfg_index,
    input  dpcp_pkg::pattern_t    cfg_data
);

    localparam dpcp_pkg::len_t MAXLEN = dpcp_pkg::len_t'(MAX_PATTERN);

    dpcp_pkg::pattern_t     pattern_a_reg, pattern_a_next;
    dpcp_pkg::pattern_t     pattern_b_reg, pattern_b_next;
    dpcp_pkg::len_t         len_a_reg, len_a_next;
    dpcp_pkg::len_t         len_b_reg, len_b_next;

    dpcp_pkg::len_t         la, lb, diff, longer;
    dpcp_pkg::win_t         win_in [MAX_PATTERN];
    dpcp_pkg::win_t         win_q  [MAX_PATTERN];
    logic                   hit_a_in [MAX_PATTERN];
    logic                   hit_b_in [MAX_PATTERN];
    logic                   hit_a_q  [MAX_PATTERN];
    logic                   hit_b_q  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok_a, ok_b;
    logic                   ma, mb, hit, hit_other, accept, advance, clear;
    dpcp_pkg::step_t        step;
    dpcp_pkg::ctrl_status_t status;

    // configuration registers
    always_comb
    begin
        pattern_a_next = pattern_a_reg;
        pattern_b_next = pattern_b_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dpcp_pkg::CFG_PATTERN_A:     pattern_a_next = cfg_data;
                dpcp_pkg::CFG_PATTERN_A_LEN: len_a_next = cfg_data[dpcp_pkg::LEN_W-1:0];
                dpcp_pkg::CFG_PATTERN_B:     pattern_b_next = cfg_data;
                dpcp_pkg::CFG_PATTERN_B_LEN: len_b_next = cfg_data[dpcp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_a_reg <= '0;
            pattern_b_reg <= '0;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
        end
        else
        begin
            pattern_a_reg <= pattern_a_next;
            pattern_b_reg <= pattern_b_next;
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
        end
    end

    assign la = (len_a_reg > MAXLEN) ? MAXLEN : len_a_reg;
    assign lb = (len_b_reg > MAXLEN) ? MAXLEN : len_b_reg;

    assign item.ready = status.slot_free;
    assign accept     = item.valid && item.ready;
    assign advance    = accept && status.searching;
    assign clear      = accept && item.last;

    // window chain
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign win_in[k]   = '{byte_a: item.byte_a, pres_a: item.has_a,
                                       byte_b: item.byte_b, pres_b: item.has_b};
                assign hit_a_in[k] = ma;
                assign hit_b_in[k] = mb;
            end
            else
            begin : g_body
                assign win_in[k]   = win_q[k-1];
                assign hit_a_in[k] = hit_a_q[k-1];
                assign hit_b_in[k] = hit_b_q[k-1];
            end

            dpcp_cell #(
                .INDEX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .clear     (clear),
                .win_in    (win_in[k]),
                .hit_a_in  (hit_a_in[k]),
                .hit_b_in  (hit_b_in[k]),
                .len_a     (la),
                .len_b     (lb),
                .pattern_a (pattern_a_reg),
                .pattern_b (pattern_b_reg),
                .win_q     (win_q[k]),
                .hit_a_q   (hit_a_q[k]),
                .hit_b_q   (hit_b_q[k]),
                .ok_a      (ok_a[k]),
                .ok_b      (ok_b[k])
            );
        end
    endgenerate

    // a pattern ends at the newest byte when every slot it covers agrees
    assign ma = (la != '0) && (&ok_a);
    assign mb = (lb != '0) && (&ok_b);

    // the longer pattern completes last; look back at the shorter one's history
    assign diff   = (la >= lb) ? (la - lb) : (lb - la);
    assign longer = (la >= lb) ? la : lb;

    always_comb
    begin
        hit_other = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (diff == dpcp_pkg::len_t'(i))
                hit_other = (la >= lb) ? hit_b_in[i] : hit_a_in[i];
        end
    end

    assign hit = (la >= lb) ? ((lb != '0) && ma && hit_other)
                            : ((la != '0) && mb && hit_other);

    assign step.accept = accept;
    assign step.last   = item.last;
    assign step.hit    = hit;
    assign step.longer = longer;
    assign step.empty  = (la == '0) || (lb == '0);

    dpcp_ctrl #(
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .status (status),
        .result (result)
    );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_pattern_common_position_unit testbench
// Streams string pairs through the unit under several pattern settings and
// random handshake pressure. Expected positions come from a behavioral model
// and are checked against every result in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          WIN_BYTES   = 8;
    localparam int unsigned POS_LIMIT   = 65535;
    localparam int          STALL_LIMIT = 5000;
    localparam int          SEGMENTS    = 9;
    localparam int          SEG_ITEMS   = 80;

    typedef struct {
        dpcp_pkg::byte_t byte_a;
        logic            has_a;
        dpcp_pkg::byte_t byte_b;
        logic            has_b;
        logic            last;
    } pair_item_t;

    typedef struct {
        logic [dpcp_pkg::POS_W-1:0] position;
        logic                       overflow;
    } pos_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    dpcp_pkg::cfg_idx_t cfg_index;
    dpcp_pkg::pattern_t cfg_data;

    dpcp_item_if   item_ch ();
    dpcp_result_if res_ch ();

    dual_pattern_common_position_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pair_item_t  pending_reqs[$];
    pos_result_t expected_positions[$];

    int src_idle_pct;
    int snk_idle_pct;
    bit item_took;
    int idle_run      = 0;
    int errors        = 0;
    int pairs_checked = 0;
    int reqs_accepted = 0;
    int cfg_writes    = 0;

    // model copy of the pattern registers and the per-pair search state
    dpcp_pkg::pattern_t pat_a = '0;
    dpcp_pkg::pattern_t pat_b = '0;
    dpcp_pkg::len_t     len_a = '0;
    dpcp_pkg::len_t     len_b = '0;
    logic [63:0]        win_a = '0;
    logic [63:0]        win_b = '0;
    logic [7:0]         hits_a = '0;
    logic [7:0]         hits_b = '0;
    int unsigned        run_a = 0;
    int unsigned        run_b = 0;
    int unsigned        item_count = 0;
    int unsigned        found_pos = 0;
    bit                 overflow_seen = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_len(input dpcp_pkg::len_t len);
        return (len > WIN_BYTES) ? WIN_BYTES : len;
    endfunction

    function automatic bit pattern_ends(input logic [63:0] win, input int unsigned run,
                                        input dpcp_pkg::pattern_t pat,
                                        input int unsigned len);
        bit ok;
        ok = (len != 0) && (run >= len);
        for (int j = 0; j < WIN_BYTES; j++)
        begin
            if (j < len)
            begin
                if (win[8*(len-1-j) +: 8] != pat[8*j +: 8])
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic void clear_search();
        win_a         = '0;
        win_b         = '0;
        hits_a        = '0;
        hits_b        = '0;
        run_a         = 0;
        run_b         = 0;
        item_count    = 0;
        found_pos     = 0;
        overflow_seen = 1'b0;
    endfunction

    // advance the search by one request; returns 1 when a result is due
    function automatic bit advance_search(input pair_item_t it, output pos_result_t res);
        int unsigned la, lb, longer;
        bit          ma, mb, hit;
        la = eff_len(len_a);
        lb = eff_len(len_b);
        if (item_count >= POS_LIMIT)
            overflow_seen = 1'b1;
        else
        begin
            win_a = {win_a[55:0], it.has_a ? it.byte_a : 8'h00};
            win_b = {win_b[55:0], it.has_b ? it.byte_b : 8'h00};
            run_a = !it.has_a ? 0 : (run_a < WIN_BYTES) ? run_a + 1 : run_a;
            run_b = !it.has_b ? 0 : (run_b < WIN_BYTES) ? run_b + 1 : run_b;
            ma = pattern_ends(win_a, run_a, pat_a, la);
            mb = pattern_ends(win_b, run_b, pat_b, lb);
            hits_a = {hits_a[6:0], ma};
            hits_b = {hits_b[6:0], mb};
            hit = 1'b0;
            // the shorter pattern must have matched at the same start position
            if (la >= lb)
            begin
                longer = la;
                if (lb != 0)
                    hit = hits_a[0] && hits_b[la - lb];
            end
            else
            begin
                longer = lb;
                if (la != 0)
                    hit = hits_b[0] && hits_a[lb - la];
            end
            if (hit && found_pos == 0)
                found_pos = item_count + 2 - longer;
            item_count++;
        end
        if (!it.last)
            return 1'b0;
        res.position = (la == 0 || lb == 0) ? '0 : found_pos[dpcp_pkg::POS_W-1:0];
        res.overflow = overflow_seen;
        clear_search();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic write_reg(input dpcp_pkg::cfg_idx_t idx, input dpcp_pkg::pattern_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            dpcp_pkg::CFG_PATTERN_A:     pat_a = data;
            dpcp_pkg::CFG_PATTERN_A_LEN: len_a = data[dpcp_pkg::LEN_W-1:0];
            dpcp_pkg::CFG_PATTERN_B:     pat_b = data;
            dpcp_pkg::CFG_PATTERN_B_LEN: len_b = data[dpcp_pkg::LEN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_patterns(input dpcp_pkg::pattern_t pa, input dpcp_pkg::len_t la,
                                input dpcp_pkg::pattern_t pb, input dpcp_pkg::len_t lb);
        write_reg(dpcp_pkg::CFG_PATTERN_A, pa);
        write_reg(dpcp_pkg::CFG_PATTERN_A_LEN, dpcp_pkg::pattern_t'(la));
        write_reg(dpcp_pkg::CFG_PATTERN_B, pb);
        write_reg(dpcp_pkg::CFG_PATTERN_B_LEN, dpcp_pkg::pattern_t'(lb));
    endtask

    task automatic queue_req(input dpcp_pkg::byte_t a, input logic ha,
                             input dpcp_pkg::byte_t b, input logic hb, input logic last);
        pair_item_t it;
        it.byte_a = a;
        it.has_a  = ha;
        it.byte_b = b;
        it.has_b  = hb;
        it.last   = last;
        pending_reqs.push_back(it);
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        while (pending_reqs.size() != 0 || item_ch.valid || expected_positions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic dpcp_pkg::byte_t pick_byte(input dpcp_pkg::pattern_t pat);
        int k;
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 6)
            return pat[8*k +: 8];
        return dpcp_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    function automatic dpcp_pkg::len_t pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return dpcp_pkg::len_t'($urandom_range(9, 15));
        return dpcp_pkg::len_t'($urandom_range(1, WIN_BYTES));
    endfunction

    function automatic dpcp_pkg::pattern_t pick_pattern();
        dpcp_pkg::pattern_t p;
        p = {$urandom, $urandom};
        // two-letter alphabet gives self-overlapping patterns
        if ($urandom_range(0, 9) < 3)
        begin
            for (int k = 0; k < WIN_BYTES; k++)
                p[8*k +: 8] = 8'h61 + dpcp_pkg::byte_t'($urandom_range(0, 1));
        end
        return p;
    endfunction

    task automatic queue_random_pair(input int n, input bit well_formed);
        dpcp_pkg::byte_t sa[64];
        dpcp_pkg::byte_t sb[64];
        bit              pa[64];
        bit              pb[64];
        int unsigned     la, lb;
        int              p, q;
        la = eff_len(len_a);
        lb = eff_len(len_b);
        for (int k = 0; k < n; k++)
        begin
            sa[k] = pick_byte(pat_a);
            sb[k] = pick_byte(pat_b);
            pa[k] = well_formed ? ($urandom_range(0, 19) != 0) : $urandom_range(0, 1);
            pb[k] = well_formed ? ($urandom_range(0, 19) != 0) : $urandom_range(0, 1);
        end
        if (well_formed)
        begin
            repeat ($urandom_range(0, 2))
            begin
                p = $urandom_range(0, n - 1);
                // sometimes one pattern lands elsewhere as a decoy
                q = ($urandom_range(0, 9) < 3) ? $urandom_range(0, n - 1) : p;
                for (int j = 0; j < la; j++)
                begin
                    if (p + j < n)
                    begin
                        sa[p+j] = pat_a[8*j +: 8];
                        pa[p+j] = 1'b1;
                    end
                end
                for (int j = 0; j < lb; j++)
                begin
                    if (q + j < n)
                    begin
                        sb[q+j] = pat_b[8*j +: 8];
                        pb[q+j] = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < n; k++)
            queue_req(sa[k], pa[k], sb[k], pb[k], k == n - 1);
    endtask

    // request driver
    always @(negedge clk)
    begin : driver
        pair_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.byte_a <= '0;
            item_ch.has_a  <= 1'b0;
            item_ch.byte_b <= '0;
            item_ch.has_b  <= 1'b0;
            item_ch.last   <= 1'b0;
        end
        else if (!item_ch.valid || item_took)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                item_ch.valid  <= 1'b1;
                item_ch.byte_a <= nxt.byte_a;
                item_ch.has_a  <= nxt.has_a;
                item_ch.byte_b <= nxt.byte_b;
                item_ch.has_b  <= nxt.has_b;
                item_ch.last   <= nxt.last;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        pair_item_t  it;
        pos_result_t want;
        bit          due;
        bit          moved;
        item_took = 1'b0;
        moved     = 1'b0;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                item_took = 1'b1;
                moved     = 1'b1;
                it.byte_a = item_ch.byte_a;
                it.has_a  = item_ch.has_a;
                it.byte_b = item_ch.byte_b;
                it.has_b  = item_ch.has_b;
                it.last   = item_ch.last;
                due = advance_search(it, want);
                if (due)
                    expected_positions.push_back(want);
                reqs_accepted++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (expected_positions.size() == 0)
                    report_mismatch($sformatf("unexpected result position %0d overflow %0b",
                                              res_ch.position, res_ch.overflow));
                else
                begin
                    want = expected_positions.pop_front();
                    if (res_ch.position !== want.position)
                        report_mismatch($sformatf("position got %0d expected %0d",
                                                  res_ch.position, want.position));
                    if (res_ch.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow got %0b expected %0b",
                                                  res_ch.overflow, want.overflow));
                    pairs_checked++;
                end
            end
            idle_run = moved ? 0 : idle_run + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_run < STALL_LIMIT)
            @(posedge clk);
        $display("dual_pattern_common_position_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int items_left;
        int n;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = dpcp_pkg::CFG_PATTERN_A;
        cfg_data       = '0;
        src_idle_pct   = 17;
        snk_idle_pct   = 58;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // "ab" and "xyz": common start at the second position
        set_patterns(64'h6261, 4'd2, 64'h7a7978, 4'd3);
        queue_req(8'h63, 1'b1, 8'h63, 1'b1, 1'b0);
        queue_req(8'h61, 1'b1, 8'h78, 1'b1, 1'b0);
        queue_req(8'h62, 1'b1, 8'h79, 1'b1, 1'b0);
        queue_req(8'h71, 1'b1, 8'h7a, 1'b1, 1'b1);
        // absent byte breaks pattern a
        queue_req(8'h61, 1'b1, 8'h78, 1'b1, 1'b0);
        queue_req(8'h62, 1'b0, 8'h79, 1'b1, 1'b0);
        queue_req(8'hff, 1'b0, 8'h00, 1'b0, 1'b1);
        drain();

        // zero pattern byte must not match an absent byte
        set_patterns(64'h0, 4'd1, {8{8'hff}}, 4'd8);
        for (int k = 0; k < 9; k++)
            queue_req(8'h00, k != 0, 8'hff, 1'b1, k == 8);
        drain();

        // length above the window size acts as a full window
        set_patterns({8{8'hff}}, 4'd15, {8{8'hff}}, 4'd8);
        for (int k = 0; k < 8; k++)
            queue_req(8'hff, 1'b1, 8'hff, 1'b1, k == 7);
        drain();
        write_reg(dpcp_pkg::CFG_PATTERN_B_LEN, dpcp_pkg::pattern_t'(4'd0));
        queue_req(8'hff, 1'b1, 8'hff, 1'b1, 1'b1);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 3)
            begin
                src_idle_pct = 58;
                snk_idle_pct = 17;
            end
            else if (seg == 6)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            set_patterns(pick_pattern(), pick_len(), pick_pattern(), pick_len());
            items_left = SEG_ITEMS;
            while (items_left > 0)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 24);
                queue_random_pair(n, $urandom_range(0, 9) < 8);
                items_left -= n;
            end
            drain();
        end

        if (expected_positions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_positions.size()));
        $display("checked %0d string pairs from %0d requests over %0d register writes",
                 pairs_checked, reqs_accepted, cfg_writes);
        $display("pattern lengths 0 to 15, gaps in both strings, three stall mixes");
        if (errors == 0)
            $display("dual_pattern_common_position_unit regression: pass");
        else
            $display("dual_pattern_common_position_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dpcp_pkg.sv
rtl/dpcp_ifs.sv
rtl/dpcp_cell.sv
rtl/dpcp_ctrl.sv
rtl/dual_pattern_common_position_unit.sv
sim/testbench.sv
